/* hdl/psu_pkg.sv */
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants of the packed sample unpacker.
// ----------------------------------------------------------------------------
package psu_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_WORD_WIDTH    = 2'd0;
    localparam logic [1:0] REG_MAX_VALUE     = 2'd1;
    localparam logic [1:0] REG_CLEAR_TOP_BIT = 2'd2;

    localparam logic [4:0]  WORD_WIDTH_RESET = 5'd5;
    localparam logic [15:0] MAX_VALUE_RESET  = 16'd16;
    localparam logic [23:0] COUNT_MAX        = 24'hFFFFFF;

    // one queued input byte
    typedef struct packed {
        logic       restart;
        logic [7:0] data_byte;
    } item_t;

    // configuration as seen by the unpack stage
    typedef struct packed {
        logic [4:0]  word_width;
        logic [15:0] max_value;
        logic        clear_top_bit;
        logic        width_clear;
    } cfg_t;

endpackage

/* hdl/psu_front.sv */
// ----------------------------------------------------------------------------
// psu_front
// Input acceptance into the byte queue and the configuration registers.
// ----------------------------------------------------------------------------
module psu_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tuser,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                q_full,
    output logic                q_push,
    output psu_pkg::item_t      q_item,
    output psu_pkg::cfg_t       cfg
);

    logic [4:0]  word_width_reg;
    logic [15:0] max_value_reg;
    logic        clear_top_bit_reg;

    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;
    assign cfg_ready = 1'b1;

    always_comb begin
        q_item.data_byte = s_tdata;
        q_item.restart   = s_tuser;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_width_reg    <= psu_pkg::WORD_WIDTH_RESET;
            max_value_reg     <= psu_pkg::MAX_VALUE_RESET;
            clear_top_bit_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                psu_pkg::REG_WORD_WIDTH:    word_width_reg    <= cfg_data[4:0];
                psu_pkg::REG_MAX_VALUE:     max_value_reg     <= cfg_data;
                psu_pkg::REG_CLEAR_TOP_BIT: clear_top_bit_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // a width write throws away the partial word in the unpack stage
    always_comb begin
        cfg.word_width    = word_width_reg;
        cfg.max_value     = max_value_reg;
        cfg.clear_top_bit = clear_top_bit_reg;
        cfg.width_clear   = cfg_valid && (cfg_index == psu_pkg::REG_WORD_WIDTH);
    end

endmodule

/* hdl/psu_fifo.sv */
// ----------------------------------------------------------------------------
// psu_fifo
// Four-entry show-ahead queue of input bytes between front and back.
// ----------------------------------------------------------------------------
module psu_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  psu_pkg::item_t      push_item,
    output logic                full,
    input  logic                pop,
    output psu_pkg::item_t      head,
    output logic                head_valid
);

    psu_pkg::item_t entry_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] fill_reg;
    logic       do_pop;

    assign full       = (fill_reg == 3'd4);
    assign head_valid = (fill_reg != 3'd0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            fill_reg   <= 3'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (push && !do_pop) begin
                fill_reg <= fill_reg + 3'd1;
            end else if (!push && do_pop) begin
                fill_reg <= fill_reg - 3'd1;
            end
        end
    end

endmodule

/* hdl/psu_back.sv */
// ----------------------------------------------------------------------------
// psu_back
// Unpack stage: completes one sample per cycle from the queued byte while the
// output register is free or being taken, and holds it in that register.
// ----------------------------------------------------------------------------
module psu_back #(
    parameter int MAX_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  psu_pkg::cfg_t       cfg,
    input  psu_pkg::item_t      head,
    input  logic                head_valid,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // sample[15:0], sample_count[39:16]
    output logic                m_tuser,   // clamped
    output logic                m_tlast
);

    localparam int HW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (MAX_WIDTH > 16) ? MAX_WIDTH : 16;

    logic [MAX_WIDTH-1:0] partial_reg, partial_next;
    logic [HW-1:0]        held_reg, held_next;
    logic [2:0]           pos_reg, pos_next;
    logic [23:0]          count_reg, count_next;

    logic        valid_reg;
    logic [15:0] sample_reg;
    logic        clamped_reg;
    logic [23:0] scount_reg;
    logic        last_reg;

    logic [HW-1:0]        w_eff;
    logic                 restart_now;
    logic [HW-1:0]        h;
    logic [MAX_WIDTH-1:0] pw;
    logic [23:0]          cnt;
    logic [3:0]           r;
    logic [7:0]           bits;
    logic [HW-1:0]        need;
    logic                 emit;
    logic [7:0]           take_bits;
    logic [MAX_WIDTH-1:0] word;
    logic [MAX_WIDTH-1:0] raw;
    logic [CW-1:0]        raw_x;
    logic                 clamp;
    logic [15:0]          sample;
    logic [7:0]           rest;
    logic [3:0]           rem;
    logic                 byte_done;
    logic                 out_free;
    logic                 step;
    logic [23:0]          cnt_inc;

    always_comb begin
        if (cfg.word_width == 5'd0) begin
            w_eff = HW'(1);
        end else if (int'(cfg.word_width) > MAX_WIDTH) begin
            w_eff = HW'(MAX_WIDTH);
        end else begin
            w_eff = HW'(cfg.word_width);
        end
    end

    // restart takes effect only on the first step of its byte
    assign restart_now = (pos_reg == 3'd0) && head.restart;
    assign h    = restart_now ? '0 : held_reg;
    assign pw   = restart_now ? '0 : partial_reg;
    assign cnt  = restart_now ? '0 : count_reg;
    assign r    = 4'd8 - {1'b0, pos_reg};
    assign bits = head.data_byte >> pos_reg;
    assign need = w_eff - h;
    assign emit = (int'(need) <= int'(r));

    assign take_bits = bits & 8'((9'd1 << need) - 9'd1);
    assign word      = pw | (MAX_WIDTH'(take_bits) << h);
    assign raw       = cfg.clear_top_bit ? (word & ~(MAX_WIDTH'(1) << (w_eff - HW'(1))))
                                         : word;
    assign raw_x     = CW'(raw);
    assign clamp     = raw_x > CW'(cfg.max_value);
    assign sample    = clamp ? cfg.max_value : raw_x[15:0];
    assign rest      = bits >> need;
    assign rem       = 4'(int'(r) - int'(need));
    assign cnt_inc   = (cnt == psu_pkg::COUNT_MAX) ? cnt : cnt + 24'd1;

    // leftover bits that cannot make another sample are absorbed now
    assign byte_done = !emit || (int'(rem) < int'(w_eff));
    assign out_free  = !valid_reg || m_tready;
    assign step      = head_valid && (!emit || out_free);
    assign pop       = step && byte_done;

    always_comb begin
        partial_next = partial_reg;
        held_next    = held_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        if (cfg.width_clear) begin
            partial_next = '0;
            held_next    = '0;
        end else if (step) begin
            if (emit) begin
                count_next = cnt_inc;
                if (byte_done) begin
                    partial_next = MAX_WIDTH'(rest);
                    held_next    = HW'(rem);
                    pos_next     = 3'd0;
                end else begin
                    partial_next = '0;
                    held_next    = '0;
                    pos_next     = pos_reg + 3'(need);
                end
            end else begin
                count_next   = cnt;
                partial_next = pw | (MAX_WIDTH'(bits) << h);
                held_next    = h + HW'(r);
                pos_next     = 3'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            held_reg    <= '0;
            pos_reg     <= 3'd0;
            count_reg   <= 24'd0;
            valid_reg   <= 1'b0;
        end else begin
            partial_reg <= partial_next;
            held_reg    <= held_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            if (step && emit) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            sample_reg  <= sample;
            clamped_reg <= clamp;
            scount_reg  <= cnt_inc;
            last_reg    <= byte_done;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {scount_reg, sample_reg};
    assign m_tuser  = clamped_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_held_below_width: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg < w_eff)
        else $error("partial word holds a full sample");

    a_mid_byte_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 3'd0 |-> head_valid)
        else $error("byte position set with no byte queued");

    a_clamp_to_max: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && clamped_reg |-> sample_reg == cfg.max_value)
        else $error("clamped sample differs from limit");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> scount_reg != 24'd0)
        else $error("emitted sample with zero count");
`endif

endmodule

/* hdl/packed_sample_unpacker.sv */
// ----------------------------------------------------------------------------
// packed_sample_unpacker
// Unpacks densely packed samples, LSB first, from a byte stream with clamping.
// ----------------------------------------------------------------------------
// Bytes enter on the s_ channel into a four-entry queue; the unpack stage takes
// bits from the queued byte and completes at most one sample per cycle while
// the output register can take it, so a byte that yields several samples holds
// the queue head until its last one is done, the single sample-completion path
// being the limit. Bits left over after the last sample of a byte are absorbed
// in that same cycle. Results leave through an output register, so bytes that
// complete no sample keep flowing while a sample waits. Samples above max_value
// are clamped and flagged on m_tuser; m_tlast marks the last sample of each
// byte. Configuration writes are taken every cycle and belong only in idle
// periods; a word_width write drops the partial sample.
// ----------------------------------------------------------------------------
module packed_sample_unpacker #(
    parameter int MAX_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte[7:0]
    input  logic        s_tuser,    // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // sample[15:0], sample_count[39:16]
    output logic        m_tuser,    // clamped
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    psu_pkg::item_t q_item;
    psu_pkg::item_t head;
    psu_pkg::cfg_t  cfg;
    logic           q_push;
    logic           q_full;
    logic           head_valid;
    logic           pop;

    psu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_item),
        .cfg        (cfg)
    );

    psu_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    psu_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

/* dv/psu_stream_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psu_stream_checker
// Watches the byte, sample and configuration channels of the packed sample
// unpacker, keeps its own copy of the unpack state, predicts every sample and
// compares each sample transfer with the oldest sample still due.
// ----------------------------------------------------------------------------
module psu_stream_checker #(
    parameter int MAX_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          samples_pending
);

    typedef struct packed {
        logic [15:0] sample;
        logic        clamped;
        logic [23:0] sample_count;
        logic        last;
    } sample_rec_t;

    sample_rec_t samples_due[$];

    logic [4:0]  width_reg;
    logic [15:0] limit_reg;
    logic        clear_top_reg;
    logic [31:0] partial_word;
    int unsigned bits_held;
    logic [23:0] emitted;

    initial begin
        fail_count      = 0;
        samples_pending = 0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic unpack_byte(input logic [7:0] data_byte, input logic restart);
        sample_rec_t recs [8];
        int          n;
        int unsigned w;
        logic [31:0] mask;
        logic [31:0] raw;
        logic        over;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        mask = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
        n = 0;
        if (restart) begin
            partial_word = '0;
            bits_held    = 0;
            emitted      = '0;
        end
        for (int i = 0; i < 8; i++) begin
            if (bits_held < w) partial_word |= 32'(data_byte[i]) << bits_held;
            bits_held++;
            if (bits_held >= w) begin
                raw = partial_word & mask;
                if (clear_top_reg) raw[w-1] = 1'b0;
                over = raw > {16'd0, limit_reg};
                if (emitted != psu_pkg::COUNT_MAX) emitted++;
                recs[n].sample       = over ? limit_reg : raw[15:0];
                recs[n].clamped      = over;
                recs[n].sample_count = emitted;
                recs[n].last         = 1'b0;
                n++;
                partial_word = '0;
                bits_held    = 0;
            end
        end
        for (int k = 0; k < n; k++) begin
            if (k == n - 1) recs[k].last = 1'b1;
            samples_due = {samples_due, recs[k]};
        end
    endtask

    task automatic check_sample();
        sample_rec_t want;
        if (samples_due.size() == 0) begin
            report_mismatch("sample with none pending", m_tdata[15:0], 0);
        end else begin
            want = samples_due.pop_front();
            if (m_tdata[15:0] != want.sample)
                report_mismatch("sample", m_tdata[15:0], want.sample);
            if (m_tdata[39:16] != want.sample_count)
                report_mismatch("sample_count", m_tdata[39:16], want.sample_count);
            if (m_tuser != want.clamped)
                report_mismatch("clamped", m_tuser, want.clamped);
            if (m_tlast != want.last)
                report_mismatch("last", m_tlast, want.last);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     = psu_pkg::WORD_WIDTH_RESET;
            limit_reg     = psu_pkg::MAX_VALUE_RESET;
            clear_top_reg = 1'b0;
            partial_word  = '0;
            bits_held     = 0;
            emitted       = '0;
            samples_due.delete();
        end else begin
            // a sample can never stem from a byte taken at the same edge
            if (m_tvalid && m_tready) check_sample();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    psu_pkg::REG_WORD_WIDTH: begin
                        width_reg    = cfg_data[4:0];
                        partial_word = '0;
                        bits_held    = 0;
                    end
                    psu_pkg::REG_MAX_VALUE: begin
                        limit_reg = cfg_data;
                    end
                    psu_pkg::REG_CLEAR_TOP_BIT: begin
                        clear_top_reg = cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) unpack_byte(s_tdata, s_tuser);
        end
        samples_pending = samples_due.size();
    end

endmodule

/* dv/tb_packed_sample_unpacker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packed_sample_unpacker
// Drives packed bytes and register writes into the unpacker under random
// gaps and stalls, directed corner bytes first and then random traffic over
// several widths and limits; the checker predicts and compares every sample.
// ----------------------------------------------------------------------------
module tb_packed_sample_unpacker;

    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         SETTLE      = 16;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // data_byte[7:0]
    logic        s_tuser;     // restart
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;     // sample[15:0], sample_count[39:16]
    logic        m_tuser;     // clamped
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int fail_count;
    int samples_pending;
    int cycle_count = 0;

    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    bit rx_hold     = 1'b0;
    bit hold_taken  = 1'b0;

    always #5 aclk = ~aclk;

    packed_sample_unpacker #(
        .MAX_WIDTH (16)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    psu_stream_checker #(
        .MAX_WIDTH (16)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .samples_pending (samples_pending)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sample receiver: random stalls, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (80) @(negedge aclk);
            end
            m_tready <= rx_calm || ($urandom_range(99) >= 18);
        end
    end

    task automatic send_byte(input logic [7:0] data_byte, input logic restart);
        while (!tx_calm && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data_byte;
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // every sample in, then room for bytes that complete nothing
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (samples_pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [4:0] width, input logic [15:0] limit,
                              input logic clear_top);
        logic [10:0] junk;
        junk = 11'($urandom);
        wait_idle();
        cfg_write(psu_pkg::REG_WORD_WIDTH, {junk, width});
        cfg_write(psu_pkg::REG_MAX_VALUE, limit);
        cfg_write(psu_pkg::REG_CLEAR_TOP_BIT, {junk, junk[3:0], clear_top});
    endtask

    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        case ($urandom_range(9))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    // mostly limits inside the sample range so clamping shows up
    function automatic logic [15:0] pick_limit(input int width);
        int          eff;
        logic [15:0] limit;
        eff = (width < 1) ? 1 : ((width > 16) ? 16 : width);
        case ($urandom_range(9))
            0:       limit = 16'h0000;
            1:       limit = 16'hFFFF;
            default: limit = 16'($urandom_range((1 << eff) - 1, 0));
        endcase
        return limit;
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(rand_byte(), $urandom_range(99) < 4);
        end
    endtask

    initial begin
        int w;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings, restart in the middle of a sample
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0);

        // write to an unused index, then width 0 behaves as width 1
        wait_idle();
        cfg_write(REG_UNUSED, 16'hFFFF);
        cfg_write(psu_pkg::REG_WORD_WIDTH, 16'hFFE0);
        cfg_write(psu_pkg::REG_MAX_VALUE, 16'h0000);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h00, 1'b0);

        // single bit samples with the top bit cleared
        set_config(5'd1, 16'd1, 1'b1);
        send_byte(8'hFF, 1'b0);

        // full width, limit at or above every value
        set_config(5'd16, 16'hFFFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);

        // oversized width falls back to 16, just above and at the limit
        set_config(5'd31, 16'h1234, 1'b0);
        send_byte(8'h35, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);

        // width rewrite drops the three leftover bits
        set_config(5'd5, 16'd16, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_idle();
        cfg_write(psu_pkg::REG_WORD_WIDTH, 16'd5);
        send_byte(8'h1F, 1'b0);

        set_config(5'd8, 16'd127, 1'b1);
        send_byte(8'hFF, 1'b0);

        // the three sensor formats
        set_config(5'd5, 16'd16, 1'b0);
        run_random(45);
        set_config(5'd11, 16'd1050, 1'b0);
        run_random(45);
        set_config(5'd8, 16'd127, 1'b1);
        run_random(45);

        set_config(5'd1, pick_limit(1), 1'($urandom_range(1)));
        run_random(40);
        set_config(5'd16, pick_limit(16), 1'b0);
        run_random(45);
        set_config(5'd20, 16'hFFFF, 1'b1);
        run_random(40);

        // steady stream, no gaps on either side
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        set_config(5'd3, pick_limit(3), 1'($urandom_range(1)));
        run_random(45);
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // receiver holds off while bytes keep coming
        set_config(5'd11, 16'd1050, 1'b0);
        tx_calm = 1'b1;
        rx_hold = 1'b1;
        run_random(45);
        tx_calm = 1'b0;

        repeat (3) begin
            w = $urandom_range(31);
            set_config(5'(w), pick_limit(w), 1'($urandom_range(1)));
            run_random(40);
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* packed_sample_unpacker.f */
hdl/psu_pkg.sv
hdl/psu_front.sv
hdl/psu_fifo.sv
hdl/psu_back.sv
hdl/packed_sample_unpacker.sv
dv/psu_stream_checker.sv
dv/tb_packed_sample_unpacker.sv
